@@ sv/sach_pkg.sv @@
// shared constants, config type and elaboration helpers for the cache tag model
package sach_pkg;

  localparam int DEF_CACHE_BYTES = 131072;
  localparam int DEF_BLOCK_BYTES = 64;
  localparam int DEF_WAYS        = 8;

  localparam int ADDR_W = 64;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ALLOC_ON_WRITE = 1'b0;
  localparam logic REG_REPLACE_MODE   = 1'b1;

  typedef struct packed {
    logic alloc_on_write;
    logic replace_mode;
  } sach_cfg_t;

  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic int ceil_log2(input int v);
    int n;
    n = 0;
    while ((1 << n) < v) begin
      n++;
    end
    return n;
  endfunction

endpackage

@@ sv/sach_ram.sv @@
// generic simple dual-port ram with registered read
module sach_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/sach_update.sv @@
// per-set lookup, victim choice and lru / tree update of one set word
module sach_update import sach_pkg::*; #(
  parameter int WAYS = DEF_WAYS,
  parameter int TAGW = 50,
  localparam int D     = ceil_log2(WAYS),
  localparam int WAYW  = (D > 0) ? D : 1,
  localparam int TREEW = (D > 0) ? ((1 << D) - 1) : 1,
  localparam int LINEW = TAGW + 1 + WAYW,
  localparam int WORDW = WAYS * LINEW + TREEW
) (
  input  logic [WORDW-1:0] rd_word,
  input  logic [TAGW-1:0]  tag,
  input  logic             opcode,
  input  sach_cfg_t        cfg,
  output logic             hit,
  output logic             wr_en,
  output logic [WORDW-1:0] wr_word
);

  logic [TAGW-1:0] tag_a  [WAYS];
  logic [WAYS-1:0] val_a;
  logic [WAYW-1:0] rank_a [WAYS];
  logic [WAYW-1:0] rank_n [WAYS];
  logic [31:0]     tree_ext;
  logic [31:0]     tree_n;
  logic            mfound, efound, lfound, fill;
  logic [WAYW-1:0] mway, eway, lru_way, plru_way, way;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tag_a[w]  = rd_word[w*LINEW +: TAGW];
      val_a[w]  = rd_word[w*LINEW + TAGW];
      rank_a[w] = rd_word[w*LINEW + TAGW + 1 +: WAYW];
    end
    tree_ext = 32'(rd_word[WAYS*LINEW +: TREEW]);
  end

  // first tag match, first invalid way, and the oldest way (ranks form a permutation)
  always_comb begin
    mfound  = 1'b0;
    efound  = 1'b0;
    lfound  = 1'b0;
    mway    = '0;
    eway    = '0;
    lru_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!mfound && tag_a[w] == tag) begin
        mfound = 1'b1;
        mway   = WAYW'(w);
      end
      if (!efound && !val_a[w]) begin
        efound = 1'b1;
        eway   = WAYW'(w);
      end
      if (!lfound && rank_a[w] == WAYW'(WAYS - 1)) begin
        lfound  = 1'b1;
        lru_way = WAYW'(w);
      end
    end
  end

  // tree walk, steering away from subtrees with no real way
  always_comb begin
    logic [4:0] node;
    logic [4:0] path;
    logic       b;
    logic [5:0] first;
    node = '0;
    path = '0;
    for (int l = 0; l < D; l++) begin
      b     = tree_ext[node];
      first = 6'({path, b}) << (D - 1 - l);
      if (first >= 6'(WAYS)) begin
        b = ~b;
      end
      node = 5'(6'(node) * 6'd2 + 6'd1 + 6'(b));
      path = {path[3:0], b};
    end
    plru_way = (6'(path) < 6'(WAYS)) ? WAYW'(path) : '0;
  end

  always_comb begin
    hit   = mfound && val_a[mway];
    fill  = !hit && !(opcode && !cfg.alloc_on_write);
    wr_en = hit || fill;
    if (mfound) begin
      way = mway;
    end else if (efound) begin
      way = eway;
    end else if (cfg.replace_mode) begin
      way = plru_way;
    end else begin
      way = lru_way;
    end
  end

  always_comb begin
    logic [4:0] node;
    logic       dir;
    for (int w = 0; w < WAYS; w++) begin
      if (WAYW'(w) == way) begin
        rank_n[w] = '0;
      end else if (rank_a[w] < rank_a[way]) begin
        rank_n[w] = rank_a[w] + WAYW'(1);
      end else begin
        rank_n[w] = rank_a[w];
      end
    end
    tree_n = tree_ext;
    node   = '0;
    for (int l = 0; l < D; l++) begin
      dir          = way[D - 1 - l];
      tree_n[node] = ~dir;
      node         = 5'(6'(node) * 6'd2 + 6'd1 + 6'(dir));
    end
  end

  always_comb begin
    wr_word = rd_word;
    for (int w = 0; w < WAYS; w++) begin
      if (fill && WAYW'(w) == way) begin
        wr_word[w*LINEW +: TAGW]  = tag;
        wr_word[w*LINEW + TAGW]   = 1'b1;
      end
      wr_word[w*LINEW + TAGW + 1 +: WAYW] = rank_n[w];
    end
    wr_word[WAYS*LINEW +: TREEW] = tree_n[TREEW-1:0];
  end

endmodule

@@ sv/set_assoc_cache_hit_miss_core.sv @@
// the hit word is registered when the lookup state advances; a lookup waits while an earlier result is held
// one access at a time: a new address word is taken only in idle, after the read and any write-back of one set ram word
// the set ram has one read and one write port; a set is read at accept and written when the lookup advances
// reset: synchronous; a clearing pass then writes every set word
// (256 at default geometry), with no access taken; config writes are taken throughout
module set_assoc_cache_hit_miss_core import sach_pkg::*; #(
  parameter int CACHE_BYTES = DEF_CACHE_BYTES,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int WAYS        = DEF_WAYS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] address,
  input  logic              opcode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int OFFB  = floor_log2(BLOCK_BYTES);
  localparam int SETS  = CACHE_BYTES / (WAYS * BLOCK_BYTES);
  localparam int IDXB  = (SETS > 0) ? floor_log2(SETS) : 0;
  localparam int TAGW  = ADDR_W - OFFB - IDXB;
  localparam int D     = ceil_log2(WAYS);
  localparam int WAYW  = (D > 0) ? D : 1;
  localparam int TREEW = (D > 0) ? ((1 << D) - 1) : 1;
  localparam int LINEW = TAGW + 1 + WAYW;
  localparam int WORDW = WAYS * LINEW + TREEW;
  localparam int DEPTH = 1 << IDXB;
  localparam int AW    = (IDXB > 0) ? IDXB : 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t          state, state_next;
  logic [AW-1:0]   clr_idx;
  logic [AW-1:0]   set_q;
  logic [TAGW-1:0] tag_q;
  logic            op_q;
  sach_cfg_t       cfg;
  logic            hit_r;

  logic             accept, adv, cfg_wr;
  logic [AW-1:0]    in_set;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WORDW-1:0] ram_wdata, ram_rdata, reset_word, upd_word;
  logic             upd_hit, upd_we;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign adv      = (state == ST_LOOK) && (!out_valid || out_ready);
  assign in_set   = (IDXB > 0) ? AW'(address >> OFFB) : '0;
  assign hit      = hit_r;

  always_comb begin
    reset_word = '0;
    for (int w = 0; w < WAYS; w++) begin
      reset_word[w*LINEW + TAGW + 1 +: WAYW] = WAYW'(w);
    end
  end

  assign ram_we    = (state == ST_CLEAR) || (adv && upd_we);
  assign ram_waddr = (state == ST_CLEAR) ? clr_idx : set_q;
  assign ram_wdata = (state == ST_CLEAR) ? reset_word : upd_word;

  sach_ram #(
    .WIDTH(WORDW),
    .DEPTH(DEPTH)
  ) u_set_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(in_set),
    .rdata(ram_rdata)
  );

  sach_update #(
    .WAYS(WAYS),
    .TAGW(TAGW)
  ) u_update (
    .rd_word(ram_rdata),
    .tag    (tag_q),
    .opcode (op_q),
    .cfg    (cfg),
    .hit    (upd_hit),
    .wr_en  (upd_we),
    .wr_word(upd_word)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= in_set;
      tag_q <= TAGW'(address >> (OFFB + IDXB));
      op_q  <= opcode;
    end
    if (adv) begin
      hit_r <= upd_hit;
    end
  end

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alloc_on_write <= 1'b1;
      cfg.replace_mode   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ALLOC_ON_WRITE: cfg.alloc_on_write <= pwdata[0];
        REG_REPLACE_MODE:   cfg.replace_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ALLOC_ON_WRITE: prdata[0] = cfg.alloc_on_write;
      REG_REPLACE_MODE:   prdata[0] = cfg.replace_mode;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOOK))
    else $error("accepted word did not move to lookup");

  a_ram_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != ST_IDLE))
    else $error("set ram written while idle");

  a_hit_writes_back: assert property (@(posedge clk) disable iff (rst)
    (adv && upd_hit) |-> ram_we)
    else $error("hit did not update recency state");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    adv |=> (out_valid && hit_r == $past(upd_hit)))
    else $error("lookup result not presented");
`endif

endmodule

@@ sim/set_assoc_cache_hit_miss_core_test.sv @@
// testbench for the set-associative cache tag core: predicts hit/miss per access and checks it
module set_assoc_cache_hit_miss_core_test;
  import sach_pkg::*;

  localparam int NSETS    = 256;
  localparam int NWAYS    = 8;
  localparam int OFF_BITS = 6;
  localparam int IDX_BITS = 8;
  localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
  localparam int TREE_D   = 3;
  localparam int WATCHDOG = 3000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ADDR_W-1:0] address = '0;
  logic              opcode = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic              hit;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // shadow copy of the tag store and replacement state
  logic [TAG_W-1:0] shadow_tag [NSETS][NWAYS];
  bit               shadow_valid [NSETS][NWAYS];
  logic [2:0]       shadow_rank [NSETS][NWAYS];
  logic [6:0]       shadow_tree [NSETS];
  sach_cfg_t        shadow_cfg;

  bit               expected_hits [$];
  int               errors = 0;
  bit               idle_on = 1'b0;
  int               stall_left = 0;
  int               quiet_cycles = 0;
  logic [7:0]       set_pool [4];
  logic [TAG_W-1:0] tag_pool [12];

  set_assoc_cache_hit_miss_core dut (.*);

  always #5 clk = ~clk;

  function automatic void mark_recent(int s, int w);
    logic [2:0] r;
    int node;
    int dir;
    r = shadow_rank[s][w];
    node = 0;
    for (int i = 0; i < NWAYS; i++)
      if (shadow_rank[s][i] < r) shadow_rank[s][i]++;
    shadow_rank[s][w] = '0;
    for (int l = 0; l < TREE_D; l++) begin
      dir = (w >> (TREE_D - 1 - l)) & 1;
      shadow_tree[s][node] = (dir == 0);
      node = 2 * node + 1 + dir;
    end
  endfunction

  function automatic int choose_victim(int s);
    int node;
    int path;
    int best;
    node = 0;
    path = 0;
    best = 0;
    if (shadow_cfg.replace_mode) begin
      for (int l = 0; l < TREE_D; l++) begin
        path = (path << 1) | shadow_tree[s][node];
        node = 2 * node + 1 + shadow_tree[s][node];
      end
      return path;
    end
    for (int i = 1; i < NWAYS; i++)
      if (shadow_rank[s][i] > shadow_rank[s][best]) best = i;
    return best;
  endfunction

  // returns the hit flag and updates the shadow state
  function automatic bit cache_access(logic [ADDR_W-1:0] a, logic wr);
    int s;
    logic [TAG_W-1:0] t;
    int match;
    int empty;
    int w;
    s = a[OFF_BITS +: IDX_BITS];
    t = a[ADDR_W-1 -: TAG_W];
    match = -1;
    empty = -1;
    for (int i = 0; i < NWAYS; i++) begin
      if (shadow_tag[s][i] == t) begin
        match = i;
        break;
      end
      if (empty < 0 && !shadow_valid[s][i]) empty = i;
    end
    if (match >= 0 && shadow_valid[s][match]) begin
      mark_recent(s, match);
      return 1'b1;
    end
    if (wr && !shadow_cfg.alloc_on_write) return 1'b0;
    w = (match >= 0) ? match : (empty >= 0) ? empty : choose_victim(s);
    shadow_tag[s][w] = t;
    shadow_valid[s][w] = 1'b1;
    mark_recent(s, w);
    return 1'b0;
  endfunction

  function automatic logic [ADDR_W-1:0] pooled_address();
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    a = {tag_pool[$urandom_range(0, 11)], set_pool[$urandom_range(0, 3)],
         6'($urandom)};
    return a;
  endfunction

  function automatic void refill_pools();
    set_pool[0] = 8'h00;
    set_pool[1] = 8'hff;
    set_pool[2] = 8'($urandom);
    set_pool[3] = 8'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 12; i++) tag_pool[i] = TAG_W'({$urandom, $urandom});
  endfunction

  task automatic send_word(logic [ADDR_W-1:0] a, logic wr);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    address <= a;
    opcode <= wr;
    do @(posedge clk); while (!in_ready);
    expected_hits.push_back(cache_access(a, wr));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [APB_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic wa, logic rm);
    drain();
    write_reg(REG_ALLOC_ON_WRITE, {31'($urandom) << 1, wa});
    write_reg(REG_REPLACE_MODE, {31'($urandom) << 1, rm});
    shadow_cfg.alloc_on_write = wa;
    shadow_cfg.replace_mode = rm;
    @(posedge clk);
  endtask

  task automatic test_directed();
    // tag zero against an invalid line: miss, then fills way 0
    send_word('0, 1'b0);
    send_word(64'h3f, 1'b0);
    send_word('1, 1'b1);
    send_word('1, 1'b0);
    // nine tags into set 0 force lru evictions of the oldest ways
    for (int i = 1; i <= 9; i++) send_word({50'(i), 8'h00, 6'h00}, 1'b0);
    send_word({50'(1), 8'h00, 6'h00}, 1'b0);
    send_word({50'(9), 8'h00, 6'h00}, 1'b1);
    set_config(1'b0, 1'b1);
    // write miss without allocate leaves the set alone
    send_word({50'h2aaaa_aaaa_aaaa, 8'h55, 6'h15}, 1'b1);
    send_word({50'h2aaaa_aaaa_aaaa, 8'h55, 6'h15}, 1'b0);
    send_word({50'h15555_5555_5555, 8'haa, 6'h2a}, 1'b1);
    for (int i = 20; i < 24; i++) send_word({50'(i), 8'h00, 6'h00}, 1'b0);
    send_word({50'(20), 8'h00, 6'h00}, 1'b1);
  endtask

  task automatic run_random(int n, bit pause_midway);
    refill_pools();
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      send_word(pooled_address(), 1'($urandom));
    end
  endtask

  task automatic test_lru_allocate();
    set_config(1'b1, 1'b0);
    run_random(310, 1'b1);
  endtask

  task automatic test_plru_no_allocate();
    set_config(1'b0, 1'b1);
    run_random(310, 1'b0);
  endtask

  task automatic test_plru_allocate();
    set_config(1'b1, 1'b1);
    run_random(310, 1'b0);
  endtask

  task automatic test_lru_no_allocate_steady();
    set_config(1'b0, 1'b0);
    idle_on = 1'b0;
    run_random(310, 1'b0);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected hit word, expected none, actual %b", $time, hit);
        errors++;
      end else begin
        if (hit !== expected_hits[0]) begin
          $display("%0t: hit mismatch, expected %b, actual %b", $time,
                   expected_hits[0], hit);
          errors++;
        end
        void'(expected_hits.pop_front());
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("set_assoc_cache_hit_miss_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NSETS; s++) begin
      shadow_tree[s] = '0;
      for (int w = 0; w < NWAYS; w++) begin
        shadow_tag[s][w] = '0;
        shadow_valid[s][w] = 1'b0;
        shadow_rank[s][w] = 3'(w);
      end
    end
    shadow_cfg.alloc_on_write = 1'b1;
    shadow_cfg.replace_mode = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;
    test_directed();
    test_lru_allocate();
    test_plru_no_allocate();
    test_plru_allocate();
    test_lru_no_allocate_steady();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("set_assoc_cache_hit_miss_core_test OK");
    end else begin
      $display("set_assoc_cache_hit_miss_core_test NOT OK");
    end
    $finish;
  end

endmodule
